### rtl/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;

  localparam int MAX_RESULTS = 32;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_id;
    logic [31:0] timeout_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        expired;
    logic [15:0] expired_id;
    logic        no_timer;
    logic [30:0] wait_ms;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### rtl/deadline_timer_queue.sv
`default_nettype none

// Deadline timer queue: a table of TABLE_DEPTH timers driven by start_i/busy_o
// requests and answered by one-cycle results on res_valid_o/res_o that the
// receiver must take when shown; nothing can hold them off. Every request
// except an add on a full table walks the whole table through the slot
// memories with a single shared deadline comparator; an add, a query or a
// cancel that finds no timer answers after one walk, and a cancel that hits
// needs a second walk to renumber ages. An expire fires up to MAX_RESULTS
// timers, one per walk, then makes one final walk; each fired id is
// reported at the end of the next walk, the last result flagged. An add on a
// full table answers STATUS_FULL in the next cycle. No clearing after reset.
module deadline_timer_queue #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire dtq_pkg::req_t req_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output dtq_pkg::res_t      res_o
);
  import dtq_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  logic [31:0] dl_mem  [TABLE_DEPTH];
  logic [15:0] own_mem [TABLE_DEPTH];
  logic [IW-1:0] age_mem [TABLE_DEPTH];

  logic [1:0]       state_q, state_d;
  req_t             req_q, req_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic             rd_v_q, rd_v_d;
  logic [IW-1:0]    rd_idx_q, rd_idx_d;
  logic [31:0]      rd_dl_q;
  logic [15:0]      rd_own_q;
  logic [IW-1:0]    rd_age_q;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]    count_q, count_d;
  logic             dec_q, dec_d;
  logic [IW-1:0]    pa_q, pa_d;
  logic             found_q, found_d;
  logic [31:0]      best_dl_q, best_dl_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [15:0]      best_own_q, best_own_d;
  logic [IW-1:0]    best_age_q, best_age_d;
  logic [NW-1:0]    n_q, n_d;
  logic             hold_v_q, hold_v_d;
  logic [15:0]      hold_id_q, hold_id_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  logic             age_we, ent_we;
  logic [IW-1:0]    age_wa;
  logic [IW-1:0]    age_wd;
  logic [31:0]      cmp_a, cmp_b, diff;
  logic             lt;
  logic             rd_valid, dec_hit;
  logic [IW-1:0]    cur_age;
  logic             more;

  assign lt   = cmp_a < cmp_b;
  assign diff = best_dl_q - req_q.now_ms;

  always_comb begin
    if (state_q == ST_END) begin
      cmp_a = req_q.now_ms;
    end else begin
      cmp_a = rd_dl_q;
    end
    cmp_b = best_dl_q;
  end

  always_comb begin
    rd_valid = valid_q[rd_idx_q];
    dec_hit  = dec_q && rd_valid && (rd_age_q > pa_q);
    cur_age  = dec_hit ? rd_age_q - IW'(1) : rd_age_q;
    more     = found_q && !lt && (n_q < NW'(MAX_RESULTS));
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    rd_v_d      = 1'b0;
    rd_idx_d    = idx_q;
    valid_d     = valid_q;
    count_d     = count_q;
    dec_d       = dec_q;
    pa_d        = pa_q;
    found_d     = found_q;
    best_dl_d   = best_dl_q;
    best_idx_d  = best_idx_q;
    best_own_d  = best_own_q;
    best_age_d  = best_age_q;
    n_d         = n_q;
    hold_v_d    = hold_v_q;
    hold_id_d   = hold_id_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    age_we      = 1'b0;
    age_wa      = rd_idx_q;
    age_wd      = '0;
    ent_we      = 1'b0;

    if (rd_v_q) begin
      if (req_q.kind == KIND_ADD && rd_valid) begin
        age_we = 1'b1;
        age_wd = rd_age_q + IW'(1);
      end else if (dec_hit) begin
        age_we = 1'b1;
        age_wd = cur_age;
      end
      case (req_q.kind)
        KIND_ADD: begin
          if (!rd_valid && !found_q) begin
            found_d    = 1'b1;
            best_idx_d = rd_idx_q;
          end
        end
        KIND_CANCEL: begin
          if (!dec_q && rd_valid && rd_own_q == req_q.request_id &&
              (!found_q || cur_age < best_age_q)) begin
            found_d    = 1'b1;
            best_idx_d = rd_idx_q;
            best_age_d = cur_age;
          end
        end
        default: begin
          if (rd_valid && (!found_q || lt)) begin
            found_d    = 1'b1;
            best_dl_d  = rd_dl_q;
            best_idx_d = rd_idx_q;
            best_own_d = rd_own_q;
            best_age_d = cur_age;
          end
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          idx_d    = '0;
          dec_d    = 1'b0;
          found_d  = 1'b0;
          n_d      = '0;
          hold_v_d = 1'b0;
          if (req_i.kind == KIND_ADD && count_q == CW'(TABLE_DEPTH)) begin
            res_valid_d  = 1'b1;
            res_d.status = STATUS_FULL;
            res_d.last   = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_v_d = 1'b1;
        if (idx_q == IW'(TABLE_DEPTH - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_END;
      end
      ST_END: begin
        state_d = ST_IDLE;
        case (req_q.kind)
          KIND_ADD: begin
            ent_we              = 1'b1;
            valid_d[best_idx_q] = 1'b1;
            count_d             = count_q + CW'(1);
            res_valid_d         = 1'b1;
            res_d.last          = 1'b1;
          end
          KIND_CANCEL: begin
            if (dec_q) begin
              res_valid_d = 1'b1;
              res_d.last  = 1'b1;
            end else if (!found_q) begin
              res_valid_d  = 1'b1;
              res_d.status = STATUS_NONE;
              res_d.last   = 1'b1;
            end else begin
              valid_d[best_idx_q] = 1'b0;
              count_d             = count_q - CW'(1);
              pa_d                = best_age_q;
              dec_d               = 1'b1;
              found_d             = 1'b0;
              idx_d               = '0;
              state_d             = ST_SCAN;
            end
          end
          KIND_EXPIRE: begin
            if (more) begin
              if (hold_v_q) begin
                res_valid_d      = 1'b1;
                res_d.expired    = 1'b1;
                res_d.expired_id = hold_id_q;
              end
              hold_v_d            = 1'b1;
              hold_id_d           = best_own_q;
              valid_d[best_idx_q] = 1'b0;
              count_d             = count_q - CW'(1);
              pa_d                = best_age_q;
              dec_d               = 1'b1;
              n_d                 = n_q + NW'(1);
              found_d             = 1'b0;
              idx_d               = '0;
              state_d             = ST_SCAN;
            end else begin
              res_valid_d      = 1'b1;
              res_d.expired    = hold_v_q;
              res_d.expired_id = hold_v_q ? hold_id_q : 16'd0;
              res_d.last       = 1'b1;
            end
          end
          default: begin
            res_valid_d    = 1'b1;
            res_d.no_timer = !found_q;
            res_d.wait_ms  = (found_q && !diff[31]) ? diff[30:0] : 31'd0;
            res_d.last     = 1'b1;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      dl_mem[best_idx_q]  <= req_q.now_ms + req_q.timeout_ms;
      own_mem[best_idx_q] <= req_q.request_id;
    end
    rd_dl_q  <= dl_mem[idx_q];
    rd_own_q <= own_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      age_mem[best_idx_q] <= '0;
    end else if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    rd_age_q <= age_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    rd_idx_q   <= rd_idx_d;
    dec_q      <= dec_d;
    pa_q       <= pa_d;
    found_q    <= found_d;
    best_dl_q  <= best_dl_d;
    best_idx_q <= best_idx_d;
    best_own_q <= best_own_d;
    best_age_q <= best_age_d;
    n_q        <= n_d;
    hold_v_q   <= hold_v_d;
    hold_id_q  <= hold_id_d;
    res_q      <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/dtq_checker.sv
`default_nettype none

module dtq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire dtq_pkg::req_t req_i,
  input wire logic          busy_o,
  input wire logic          res_valid_o,
  input wire dtq_pkg::res_t res_o
);
  import dtq_pkg::*;

  a_walk_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.kind != KIND_ADD) |=> busy_o)
    else $error("non-add request did not start a table walk");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o || start_i))
    else $error("result without a pending request");

  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (busy_o == !res_o.last))
    else $error("busy does not match the last flag");

  a_middle_is_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.expired)
    else $error("non-final result that is not an expiry");

  a_expiry_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.expired |-> (res_o.status == STATUS_OK) && !res_o.no_timer)
    else $error("expiry result carries status or no-timer flag");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .req_i       (req_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire
